>>> hdl/idgd_pkg.sv
package idgd_pkg;

  localparam int ACT_W = 16;
  localparam int WGT_W = 4;
  localparam int SCL_W = 16;
  localparam int ACC_W = 32;
  localparam int FAC_W = 32;
  localparam int OUT_W = 32;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [FAC_W-1:0] FACTOR_RESET = 32'd33819;
  localparam logic REG_DEQUANT = 1'b0;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic ovf;
    logic signed [SCL_W-1:0] scale;
  } col_t;

endpackage

>>> hdl/idgd_if.sv
interface idgd_item_if;
  import idgd_pkg::*;
  logic valid;
  logic ready;
  logic signed [ACT_W-1:0] activation;
  logic signed [WGT_W-1:0] weight;
  logic signed [SCL_W-1:0] group_scale;
  logic last;

  modport source(output valid, activation, weight, group_scale, last, input ready);
  modport sink(input valid, activation, weight, group_scale, last, output ready);
endinterface

interface idgd_result_if;
  import idgd_pkg::*;
  logic valid;
  logic ready;
  logic signed [OUT_W-1:0] column_value;
  logic saturated;

  modport source(output valid, column_value, saturated, input ready);
  modport sink(input valid, column_value, saturated, output ready);
endinterface

>>> hdl/idgd_front.sv
module idgd_front (
  input  logic          clk,
  input  logic          rst,
  idgd_item_if.sink     item,
  input  logic          full,
  output logic          push_valid,
  output idgd_pkg::col_t push_data
);
  import idgd_pkg::*;

  logic signed [ACC_W-1:0] acc, acc_next;
  logic ovf, ovf_next;
  logic signed [ACT_W+WGT_W-1:0] prod;
  logic signed [ACC_W:0] sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic hit;
  logic accept;

  assign item.ready = !full;
  assign accept = item.valid && item.ready;

  // saturating multiply-accumulate
  assign prod = item.activation * item.weight;
  assign sum = {acc[ACC_W-1], acc} + (ACC_W+1)'(prod);
  assign hit = sum[ACC_W] ^ sum[ACC_W-1];
  assign acc_sat = hit ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];

  assign push_valid = accept && item.last;
  assign push_data = '{sum: acc_sat, ovf: ovf | hit, scale: item.group_scale};

  always_comb begin
    acc_next = acc;
    ovf_next = ovf;
    if (accept) begin
      if (item.last) begin
        acc_next = '0;
        ovf_next = 1'b0;
      end else begin
        acc_next = acc_sat;
        ovf_next = ovf | hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      ovf <= 1'b0;
    end else begin
      acc <= acc_next;
      ovf <= ovf_next;
    end
  end

endmodule

>>> hdl/idgd_queue.sv
module idgd_queue #(
  parameter int DEPTH = idgd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  idgd_pkg::col_t push_data,
  output logic           full,
  output logic           pop_valid,
  input  logic           pop_ready,
  output idgd_pkg::col_t pop_data
);
  import idgd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  col_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic push, pop;

  assign full = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign push = push_valid && !full;
  assign pop = pop_valid && pop_ready;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/idgd_back.sv
module idgd_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [idgd_pkg::FAC_W-1:0]   factor,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  idgd_pkg::col_t               q_data,
  idgd_result_if.source                result
);
  import idgd_pkg::*;

  localparam int TW = ACC_W + SCL_W;
  localparam int MW = TW - 1;
  localparam int LW = MW / 2 + 1;
  localparam int HW = MW - LW;
  localparam int PW = MW + FAC_W;
  localparam int QS = 43;
  localparam int QW = PW - QS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_MAG  = 3'd2;
  localparam logic [2:0] S_PLO  = 3'd3;
  localparam logic [2:0] S_PHI  = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;
  localparam logic [2:0] S_RES  = 3'd6;

  localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (QS - 1);
  localparam logic [QW-1:0] NEG_LIMIT = QW'(1) << (OUT_W - 1);

  logic [2:0] state;
  logic signed [ACC_W-1:0] sum_r;
  logic ovf_r;
  logic signed [SCL_W-1:0] scale_r;
  logic signed [TW-1:0] t;
  logic neg;
  logic [MW-1:0] m;
  logic [LW+FAC_W-1:0] p_lo;
  logic [HW+FAC_W-1:0] p_hi;
  logic [QW-1:0] q;
  logic [PW-1:0] total;
  logic big, hit;
  logic signed [OUT_W-1:0] value;
  logic out_valid;
  logic signed [OUT_W-1:0] out_value;
  logic out_sat;
  logic out_free;
  logic load;

  assign q_ready = (state == S_IDLE);
  assign out_free = !out_valid || result.ready;
  assign load = (state == S_RES) && out_free;

  assign total = {p_hi, {LW{1'b0}}} + PW'(p_lo) + ROUND_HALF;

  // signed saturation of the rounded magnitude
  assign big = (q[QW-1:OUT_W-1] != '0);
  assign hit = neg ? (big && (q != NEG_LIMIT)) : big;
  always_comb begin
    if (neg) begin
      value = hit ? ACC_MIN : -q[OUT_W-1:0];
    end else begin
      value = hit ? ACC_MAX : q[OUT_W-1:0];
    end
  end

  assign result.valid = out_valid;
  assign result.column_value = out_value;
  assign result.saturated = out_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (q_valid) state <= S_MUL;
        S_MUL: state <= S_MAG;
        S_MAG: state <= S_PLO;
        S_PLO: state <= S_PHI;
        S_PHI: state <= S_SUM;
        S_SUM: state <= S_RES;
        S_RES: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          sum_r <= q_data.sum;
          ovf_r <= q_data.ovf;
          scale_r <= q_data.scale;
        end
      end
      S_MUL: t <= sum_r * scale_r;
      S_MAG: begin
        neg <= t[TW-1];
        m <= t[TW-1] ? MW'(-t) : MW'(t);
      end
      S_PLO: p_lo <= m[LW-1:0] * factor;
      S_PHI: p_hi <= m[MW-1:LW] * factor;
      S_SUM: q <= total[PW-1:QS];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value <= value;
      out_sat <= ovf_r | hit;
    end
  end

endmodule

>>> hdl/int4_group_dequant_dot_product.sv
// int4 group-dequantized dot product, one output column per burst of beats
//
// item channel: one activation and one signed int4 weight per beat; the beat
// with last set also carries the column's group scale and closes the column
// result channel: one beat per column, the saturated Q.11 column value and a
// flag set when the accumulator or the output clamped
// apb port: one register at byte address 0, the Q0.32 dequant factor
//
// the accumulator takes one item beat per cycle while the queue is not full;
// a closed column moves into a small queue and a scaling sequencer works it
// off through its multiply, magnitude, low and high partial-product, sum and
// result states, with two partial-product passes over the 47-bit magnitude
// on a 24x32 multiplier; it takes a new column only when back in idle
// reset clears the accumulator, the queue and the result valid flag and loads
// the factor's reset value
// a stalled result holds in its output register; the sequencer may finish the
// next column behind it, and item beats keep flowing until the queue fills
module int4_group_dequant_dot_product #(
  parameter int QUEUE_DEPTH = idgd_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  idgd_item_if.sink                     item,
  idgd_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [idgd_pkg::ADDR_W-1:0]   paddr,
  input  logic [idgd_pkg::DATA_W-1:0]   pwdata,
  output logic [idgd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import idgd_pkg::*;

  logic [FAC_W-1:0] factor;
  logic sel_factor;
  logic push_valid;
  col_t push_data;
  logic full;
  logic pop_valid, pop_ready;
  col_t pop_data;

  assign pready = 1'b1;
  assign sel_factor = (paddr[ADDR_W-1:2] == (ADDR_W-2)'(REG_DEQUANT));
  assign prdata = sel_factor ? DATA_W'(factor) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= FACTOR_RESET;
    end else if (psel && penable && pwrite && pready && sel_factor) begin
      factor <= pwdata[FAC_W-1:0];
    end
  end

  idgd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .full       (full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  idgd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  idgd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .factor  (factor),
    .q_valid (pop_valid),
    .q_ready (pop_ready),
    .q_data  (pop_data),
    .result  (result)
  );

endmodule

>>> hdl/idgd_checker.sv
module idgd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [idgd_pkg::OUT_W-1:0]    res_value,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [idgd_pkg::ADDR_W-1:0]   paddr,
  input logic [idgd_pkg::DATA_W-1:0]   pwdata,
  input logic [idgd_pkg::DATA_W-1:0]   prdata,
  input logic                          pready
);
  import idgd_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result beat right after reset");

  a_no_early_result: assert property (@(posedge clk)
    $rose(res_valid) |-> (!$past(rst, 1) && !$past(rst, 2)))
    else $error("result beat too soon after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_value))
    else $error("stalled result beat changed");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == '0))
    |=> !(psel && !pwrite && (paddr[ADDR_W-1:2] == '0)) || (prdata == $past(pwdata)))
    else $error("factor readback mismatch");

endmodule

bind int4_group_dequant_dot_product idgd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_value (result.column_value),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);
